// ===== rtl/rpfd_pkg.sv =====
package rpfd_pkg;

   localparam int GAIN_W    = 31;
   localparam int WEIGHT_W  = 17;
   localparam int DATA_W    = 32;
   localparam int DT_W      = 16;
   localparam int CSR_IDX_W = 2;
   localparam int MUL_W     = 33;
   localparam int PROD_W    = 66;
   localparam int DIVD_W    = 64;
   localparam int DIVS_W    = 20;

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT = 2'd3;

   localparam logic [GAIN_W-1:0]   GAIN_P_RESET = 31'd9830;
   localparam logic [GAIN_W-1:0]   GAIN_I_RESET = 31'd7864;
   localparam logic [GAIN_W-1:0]   GAIN_D_RESET = 31'd328;
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'd13107;
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 17'd65536;

   localparam logic signed [32:0] INTEG_LIMIT = 33'sd13107200;
   localparam logic signed [39:0] ITERM_LIMIT = 40'sd9830400;

   localparam logic [DIVS_W-1:0] US_PER_S = 20'd1000000;
   localparam logic [DIVS_W-1:0] HALF_S   = 20'd500000;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_MUL_P,
      OP_TAKE_P,
      OP_MUL_INC,
      OP_DIV_INC,
      OP_TAKE_INC,
      OP_MUL_I,
      OP_TAKE_I,
      OP_MUL_D,
      OP_TAKE_A,
      OP_MUL_AHI,
      OP_TAKE_AHI,
      OP_MUL_ALO,
      OP_TAKE_ALO,
      OP_DIV_RAW,
      OP_TAKE_RAW,
      OP_MUL_F0,
      OP_TAKE_F0,
      OP_MUL_F1,
      OP_TAKE_F1,
      OP_SUM,
      OP_ZERO
   } op_type;

   typedef struct packed {
      op_type op;
      logic   div_start;
      logic   emit;
   } cmd_type;

   typedef struct packed {
      logic dt_zero;
      logic hold;
   } status_type;

   typedef struct packed {
      logic [GAIN_W-1:0]   gain_p;
      logic [GAIN_W-1:0]   gain_i;
      logic [GAIN_W-1:0]   gain_d;
      logic [WEIGHT_W-1:0] weight;
   } cfg_type;

endpackage

// ===== rtl/rpfd_div.sv =====
module rpfd_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [rpfd_pkg::DIVD_W-1:0]      dividend,
   input  logic [rpfd_pkg::DIVS_W-1:0]      divisor,
   output logic [rpfd_pkg::DIVD_W-1:0]      quotient,
   output logic                             busy,
   output logic                             done
);

   localparam int STEPS     = rpfd_pkg::DIVD_W / 2;
   localparam int CNT_W     = $clog2(STEPS);

   logic [rpfd_pkg::DIVD_W-1:0] quo_ff, quo_in;
   logic [rpfd_pkg::DIVS_W-1:0] rem_ff, rem_in;
   logic [rpfd_pkg::DIVS_W-1:0] div_ff;
   logic [CNT_W-1:0]            cnt_ff;
   logic                        busy_ff;
   logic                        done_ff;

   always_comb begin
      logic [rpfd_pkg::DIVS_W:0] trial;
      quo_in = quo_ff;
      rem_in = rem_ff;
      for (int k = 0; k < 2; k++) begin
         trial  = {rem_in, quo_in[rpfd_pkg::DIVD_W-1]};
         quo_in = {quo_in[rpfd_pkg::DIVD_W-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in    = rpfd_pkg::DIVS_W'(trial - {1'b0, div_ff});
            quo_in[0] = 1'b1;
         end else begin
            rem_in = trial[rpfd_pkg::DIVS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(STEPS - 1);
         end else if (busy_ff) begin
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign quotient = quo_ff;
   assign busy     = busy_ff;
   assign done     = done_ff;

endmodule

// ===== rtl/rpfd_ctrl.sv =====
module rpfd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 out_free,
   input  logic                 div_done,
   input  rpfd_pkg::status_type status,
   output logic                 busy,
   output rpfd_pkg::cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MUL_P,
      ST_TAKE_P,
      ST_MUL_INC,
      ST_DIV_INC,
      ST_WAIT_INC,
      ST_TAKE_INC,
      ST_MUL_I,
      ST_TAKE_I,
      ST_MUL_D,
      ST_TAKE_A,
      ST_MUL_AHI,
      ST_TAKE_AHI,
      ST_MUL_ALO,
      ST_TAKE_ALO,
      ST_DIV_RAW,
      ST_WAIT_RAW,
      ST_TAKE_RAW,
      ST_MUL_F0,
      ST_TAKE_F0,
      ST_MUL_F1,
      ST_TAKE_F1,
      ST_FINISH,
      ST_ZERO
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in      = state_ff;
      cmd.op        = rpfd_pkg::OP_NONE;
      cmd.div_start = 1'b0;
      cmd.emit      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = rpfd_pkg::OP_LOAD;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = status.dt_zero ? ST_ZERO : ST_MUL_P;
         end
         ST_MUL_P: begin
            cmd.op   = rpfd_pkg::OP_MUL_P;
            state_in = ST_TAKE_P;
         end
         ST_TAKE_P: begin
            cmd.op   = rpfd_pkg::OP_TAKE_P;
            state_in = status.hold ? ST_MUL_I : ST_MUL_INC;
         end
         ST_MUL_INC: begin
            cmd.op   = rpfd_pkg::OP_MUL_INC;
            state_in = ST_DIV_INC;
         end
         ST_DIV_INC: begin
            cmd.op        = rpfd_pkg::OP_DIV_INC;
            cmd.div_start = 1'b1;
            state_in      = ST_WAIT_INC;
         end
         ST_WAIT_INC: begin
            if (div_done) state_in = ST_TAKE_INC;
         end
         ST_TAKE_INC: begin
            cmd.op   = rpfd_pkg::OP_TAKE_INC;
            state_in = ST_MUL_I;
         end
         ST_MUL_I: begin
            cmd.op   = rpfd_pkg::OP_MUL_I;
            state_in = ST_TAKE_I;
         end
         ST_TAKE_I: begin
            cmd.op   = rpfd_pkg::OP_TAKE_I;
            state_in = status.hold ? ST_FINISH : ST_MUL_D;
         end
         ST_MUL_D: begin
            cmd.op   = rpfd_pkg::OP_MUL_D;
            state_in = ST_TAKE_A;
         end
         ST_TAKE_A: begin
            cmd.op   = rpfd_pkg::OP_TAKE_A;
            state_in = ST_MUL_AHI;
         end
         ST_MUL_AHI: begin
            cmd.op   = rpfd_pkg::OP_MUL_AHI;
            state_in = ST_TAKE_AHI;
         end
         ST_TAKE_AHI: begin
            cmd.op   = rpfd_pkg::OP_TAKE_AHI;
            state_in = ST_MUL_ALO;
         end
         ST_MUL_ALO: begin
            cmd.op   = rpfd_pkg::OP_MUL_ALO;
            state_in = ST_TAKE_ALO;
         end
         ST_TAKE_ALO: begin
            cmd.op   = rpfd_pkg::OP_TAKE_ALO;
            state_in = ST_DIV_RAW;
         end
         ST_DIV_RAW: begin
            cmd.op        = rpfd_pkg::OP_DIV_RAW;
            cmd.div_start = 1'b1;
            state_in      = ST_WAIT_RAW;
         end
         ST_WAIT_RAW: begin
            if (div_done) state_in = ST_TAKE_RAW;
         end
         ST_TAKE_RAW: begin
            cmd.op   = rpfd_pkg::OP_TAKE_RAW;
            state_in = ST_MUL_F0;
         end
         ST_MUL_F0: begin
            cmd.op   = rpfd_pkg::OP_MUL_F0;
            state_in = ST_TAKE_F0;
         end
         ST_TAKE_F0: begin
            cmd.op   = rpfd_pkg::OP_TAKE_F0;
            state_in = ST_MUL_F1;
         end
         ST_MUL_F1: begin
            cmd.op   = rpfd_pkg::OP_MUL_F1;
            state_in = ST_TAKE_F1;
         end
         ST_TAKE_F1: begin
            cmd.op   = rpfd_pkg::OP_TAKE_F1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.op   = rpfd_pkg::OP_SUM;
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_ZERO: begin
            if (out_free) begin
               cmd.op   = rpfd_pkg::OP_ZERO;
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== rtl/rpfd_datapath.sv =====
module rpfd_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  rpfd_pkg::cmd_type                cmd,
   input  rpfd_pkg::cfg_type                cfg,
   input  logic signed [31:0]               req_setpoint,
   input  logic signed [31:0]               req_measured_rate,
   input  logic [15:0]                      req_step_time_us,
   input  logic                             req_hold,
   input  logic [rpfd_pkg::DIVD_W-1:0]      div_quotient,
   output logic [rpfd_pkg::DIVD_W-1:0]      div_dividend,
   output logic [rpfd_pkg::DIVS_W-1:0]      div_divisor,
   output rpfd_pkg::status_type             status,
   output logic signed [31:0]               drive
);

   logic signed [32:0] err_ff, diff_ff;
   logic signed [31:0] meas_ff;
   logic [15:0]        dt_ff;
   logic               hold_ff;
   logic signed [rpfd_pkg::PROD_W-1:0] mul_ff;
   logic signed [47:0] p_ff;
   logic signed [39:0] i_ff;
   logic [46:0]        a_ff;
   logic [63:0]        num_ff;
   logic signed [31:0] raw_ff;
   logic signed [49:0] facc_ff;
   logic signed [31:0] isum_ff, last_ff, filt_ff;
   logic signed [31:0] drive_ff;

   logic signed [rpfd_pkg::MUL_W-1:0] mul_a, mul_b;
   logic signed [32:0] err_abs, diff_abs;
   logic [16:0]        alpha;
   logic [16:0]        alpha_c;
   logic signed [32:0] inc;
   logic signed [32:0] isum_next;
   logic signed [39:0] iprod;
   logic               a_big;
   logic               pos_sat, neg_sat;
   logic signed [49:0] fsum;
   logic signed [49:0] total;

   assign err_abs  = err_ff[32] ? -err_ff : err_ff;
   assign diff_abs = diff_ff[32] ? -diff_ff : diff_ff;
   assign alpha    = (cfg.weight > rpfd_pkg::WEIGHT_ONE) ? rpfd_pkg::WEIGHT_ONE : cfg.weight;
   assign alpha_c  = rpfd_pkg::WEIGHT_ONE - alpha;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         rpfd_pkg::OP_MUL_P: begin
            mul_a = {2'b00, cfg.gain_p};
            mul_b = err_ff;
         end
         rpfd_pkg::OP_MUL_INC: begin
            mul_a = {1'b0, err_abs[31:0]};
            mul_b = {17'd0, dt_ff};
         end
         rpfd_pkg::OP_MUL_I: begin
            mul_a = {2'b00, cfg.gain_i};
            mul_b = {isum_ff[31], isum_ff};
         end
         rpfd_pkg::OP_MUL_D: begin
            mul_a = {2'b00, cfg.gain_d};
            mul_b = {1'b0, diff_abs[31:0]};
         end
         rpfd_pkg::OP_MUL_AHI: begin
            mul_a = {11'd0, a_ff[42:21]};
            mul_b = {13'd0, rpfd_pkg::US_PER_S};
         end
         rpfd_pkg::OP_MUL_ALO: begin
            mul_a = {12'd0, a_ff[20:0]};
            mul_b = {13'd0, rpfd_pkg::US_PER_S};
         end
         rpfd_pkg::OP_MUL_F0: begin
            mul_a = {filt_ff[31], filt_ff};
            mul_b = {16'd0, alpha_c};
         end
         rpfd_pkg::OP_MUL_F1: begin
            mul_a = {raw_ff[31], raw_ff};
            mul_b = {16'd0, alpha};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      div_dividend = num_ff;
      div_divisor  = {4'd0, dt_ff};
      if (cmd.op == rpfd_pkg::OP_DIV_INC) begin
         div_dividend = 64'(mul_ff[47:0]) + 64'(rpfd_pkg::HALF_S);
         div_divisor  = rpfd_pkg::US_PER_S;
      end
   end

   assign inc = err_ff[32] ? -$signed({4'd0, div_quotient[28:0]})
                           :  $signed({4'd0, div_quotient[28:0]});

   always_comb begin
      isum_next = {isum_ff[31], isum_ff} + inc;
      if (isum_next > rpfd_pkg::INTEG_LIMIT) begin
         isum_next = rpfd_pkg::INTEG_LIMIT;
      end else if (isum_next < -rpfd_pkg::INTEG_LIMIT) begin
         isum_next = -rpfd_pkg::INTEG_LIMIT;
      end
   end

   always_comb begin
      iprod = mul_ff[55:16];
      if (hold_ff) begin
         if (iprod > rpfd_pkg::ITERM_LIMIT) begin
            iprod = rpfd_pkg::ITERM_LIMIT;
         end else if (iprod < -rpfd_pkg::ITERM_LIMIT) begin
            iprod = -rpfd_pkg::ITERM_LIMIT;
         end
      end
   end

   assign a_big   = |a_ff[46:43];
   assign pos_sat = a_big || (|div_quotient[63:31]);
   assign neg_sat = a_big || (|div_quotient[63:32])
                    || (div_quotient[31] && (|div_quotient[30:0]));

   assign fsum  = facc_ff + mul_ff[49:0];
   assign total = {{2{p_ff[47]}}, p_ff} + {{10{i_ff[39]}}, i_ff}
                  + (hold_ff ? 50'sd0 : {{18{filt_ff[31]}}, filt_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         isum_ff <= '0;
         last_ff <= '0;
         filt_ff <= '0;
      end else begin
         case (cmd.op)
            rpfd_pkg::OP_TAKE_INC: isum_ff <= isum_next[31:0];
            rpfd_pkg::OP_TAKE_F1:  filt_ff <= fsum[47:16];
            rpfd_pkg::OP_SUM:      last_ff <= meas_ff;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         rpfd_pkg::OP_LOAD: begin
            err_ff  <= {req_setpoint[31], req_setpoint}
                       - {req_measured_rate[31], req_measured_rate};
            diff_ff <= {last_ff[31], last_ff} - {req_measured_rate[31], req_measured_rate};
            meas_ff <= req_measured_rate;
            dt_ff   <= req_step_time_us;
            hold_ff <= req_hold;
         end
         rpfd_pkg::OP_MUL_P,
         rpfd_pkg::OP_MUL_INC,
         rpfd_pkg::OP_MUL_I,
         rpfd_pkg::OP_MUL_D,
         rpfd_pkg::OP_MUL_AHI,
         rpfd_pkg::OP_MUL_ALO,
         rpfd_pkg::OP_MUL_F0,
         rpfd_pkg::OP_MUL_F1: mul_ff <= mul_a * mul_b;
         rpfd_pkg::OP_TAKE_P:   p_ff <= mul_ff[63:16];
         rpfd_pkg::OP_TAKE_I:   i_ff <= iprod;
         rpfd_pkg::OP_TAKE_A:   a_ff <= mul_ff[62:16];
         rpfd_pkg::OP_TAKE_AHI: num_ff <= 64'(mul_ff[41:0]) << 21;
         rpfd_pkg::OP_TAKE_ALO: num_ff <= num_ff + 64'(mul_ff[40:0]) + 64'(dt_ff[15:1]);
         rpfd_pkg::OP_TAKE_RAW: begin
            if (diff_ff[32]) begin
               raw_ff <= neg_sat ? 32'sh80000000 : $signed(~div_quotient[31:0] + 32'd1);
            end else begin
               raw_ff <= pos_sat ? 32'sh7FFFFFFF : $signed(div_quotient[31:0]);
            end
         end
         rpfd_pkg::OP_TAKE_F0: facc_ff <= mul_ff[49:0];
         rpfd_pkg::OP_SUM: begin
            if (total > 50'sh7FFFFFFF) begin
               drive_ff <= 32'sh7FFFFFFF;
            end else if (total < -50'sh80000000) begin
               drive_ff <= 32'sh80000000;
            end else begin
               drive_ff <= total[31:0];
            end
         end
         rpfd_pkg::OP_ZERO: drive_ff <= '0;
         default: ;
      endcase
   end

   assign status.dt_zero = (dt_ff == '0);
   assign status.hold    = hold_ff;
   assign drive          = drive_ff;

endmodule

// ===== rtl/rate_pid_filtered_derivative.sv =====
// Rate PID controller, derivative on measurement with first-order low-pass.
// Request channel: req_valid/req_stall carry the setpoint, measured rate
// (signed Q16.16), step time in microseconds and the hold flag. A request is
// taken when req_valid is high and req_stall low; req_stall stays high while
// a request is being worked on, so one request is in flight at a time.
// Response channel: rsp_valid/rsp_stall carry one saturated Q16.16 drive per
// request, in request order, from an output register.
// In normal mode two 64-bit divisions at two quotient bits per cycle run
// in the shared divider, and one shared 33x33 multiplier is used eight
// times; hold mode skips both divisions and the derivative, and a zero
// step time gives a zero drive. The next request is taken the cycle after
// the response is registered.
// A stalled response holds its value; a finished request waits for the
// output register to empty, and the request side stays stalled meanwhile.
// Reset clears the integral, stored measurement and filter state, restores
// the default gains and weight, and empties the output register.
// Configuration writes through csr_write_enable/csr_index/csr_data take
// effect at once and must be done while no request is in flight.
module rate_pid_filtered_derivative (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [31:0]                  req_setpoint,
   input  logic signed [31:0]                  req_measured_rate,
   input  logic [15:0]                         req_step_time_us,
   input  logic                                req_hold,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [31:0]                  rsp_drive,
   input  logic                                csr_write_enable,
   input  logic [rpfd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rpfd_pkg::GAIN_W-1:0]         csr_data
);

   rpfd_pkg::cfg_type    cfg_ff;
   rpfd_pkg::cmd_type    cmd;
   rpfd_pkg::status_type status;
   logic                 busy;
   logic                 rsp_valid_ff;
   logic                 out_free;
   logic                 div_busy, div_done;
   logic [rpfd_pkg::DIVD_W-1:0] div_quotient, div_dividend;
   logic [rpfd_pkg::DIVS_W-1:0] div_divisor;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p <= rpfd_pkg::GAIN_P_RESET;
         cfg_ff.gain_i <= rpfd_pkg::GAIN_I_RESET;
         cfg_ff.gain_d <= rpfd_pkg::GAIN_D_RESET;
         cfg_ff.weight <= rpfd_pkg::WEIGHT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            rpfd_pkg::CSR_GAIN_P: cfg_ff.gain_p <= csr_data;
            rpfd_pkg::CSR_GAIN_I: cfg_ff.gain_i <= csr_data;
            rpfd_pkg::CSR_GAIN_D: cfg_ff.gain_d <= csr_data;
            rpfd_pkg::CSR_WEIGHT: cfg_ff.weight <= csr_data[rpfd_pkg::WEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   rpfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .div_done  (div_done),
      .status    (status),
      .busy      (busy),
      .cmd       (cmd)
   );

   rpfd_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .cfg               (cfg_ff),
      .req_setpoint      (req_setpoint),
      .req_measured_rate (req_measured_rate),
      .req_step_time_us  (req_step_time_us),
      .req_hold          (req_hold),
      .div_quotient      (div_quotient),
      .div_dividend      (div_dividend),
      .div_divisor       (div_divisor),
      .status            (status),
      .drive             (rsp_drive)
   );

   rpfd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .busy     (div_busy),
      .done     (div_done)
   );

   assign req_stall = busy;
   assign rsp_valid = rsp_valid_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request side not stalled after acceptance");

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !div_busy)
      else $error("divider restarted while busy");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> out_free)
      else $error("response overwritten while stalled");

   a_done_in_flight: assert property (@(posedge clock) disable iff (reset)
      div_done |-> busy)
      else $error("division finished with no request in flight");

endmodule

// ===== sim/tb_rate_pid_filtered_derivative.sv =====
`timescale 1ns / 100ps

module tb_rate_pid_filtered_derivative;

   localparam longint DRIVE_MAX = 64'sh7FFFFFFF;
   localparam longint DRIVE_MIN = -64'sh80000000;
   localparam longint LIM_INTEG = 64'sd13107200;
   localparam longint LIM_ITERM = 64'sd9830400;
   localparam longint CYCLE_LIMIT = 64'd2000000;

   typedef struct packed {
      logic signed [31:0] setpoint;
      logic signed [31:0] measured_rate;
      logic [15:0]        step_time_us;
      logic               hold;
   } request_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_setpoint = '0;
   logic signed [31:0] req_measured_rate = '0;
   logic [15:0] req_step_time_us = '0;
   logic req_hold = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_drive;
   logic csr_write_enable = 1'b0;
   logic [rpfd_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [rpfd_pkg::GAIN_W-1:0] csr_data = '0;

   request_type pending_requests[$];
   logic signed [31:0] expected_drive[$];

   longint gain_p, gain_i, gain_d, weight;
   longint integ_sum, last_meas, deriv_filt;

   int mismatches = 0;
   int responses = 0;
   int requests_sent = 0;
   int hold_count = 0;
   int zero_dt_count = 0;
   int send_wait = 0;
   int recv_wait = 0;
   longint cycles = 0;

   rate_pid_filtered_derivative u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_setpoint(req_setpoint), .req_measured_rate(req_measured_rate),
      .req_step_time_us(req_step_time_us), .req_hold(req_hold),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_drive(rsp_drive),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic longint floor_div16(longint x);
      return x >>> 16;
   endfunction

   function automatic longint limit(longint x, longint lo, longint hi);
      return x < lo ? lo : (x > hi ? hi : x);
   endfunction

   function automatic longint derivative_rate(longint diff, longint dt);
      logic neg;
      logic [127:0] mag, a, q;
      neg = diff < 0;
      mag = neg ? -diff : diff;
      a = (128'(gain_d) * mag) >> 16;
      if (a >= (128'd1 << 43)) q = 128'd1 << 40;
      else q = (a * 128'd1000000 + 128'(dt / 2)) / 128'(dt);
      if (neg) return q > 128'h80000000 ? DRIVE_MIN : -longint'(q);
      return q > 128'h7FFFFFFF ? DRIVE_MAX : longint'(q);
   endfunction

   function automatic logic signed [31:0] controller_drive(request_type r);
      longint err, pterm, iterm, total, alpha, rate, dt, inc;
      logic [127:0] mag;
      dt = r.step_time_us;
      if (dt == 0) return '0;
      err = longint'(r.setpoint) - longint'(r.measured_rate);
      pterm = floor_div16(gain_p * err);
      if (r.hold) begin
         iterm = limit(floor_div16(gain_i * integ_sum), -LIM_ITERM, LIM_ITERM);
         last_meas = r.measured_rate;
         total = pterm + iterm;
      end else begin
         mag = err < 0 ? -err : err;
         inc = longint'((mag * 128'(dt) + 128'd500000) / 128'd1000000);
         if (err < 0) inc = -inc;
         integ_sum = limit(integ_sum + inc, -LIM_INTEG, LIM_INTEG);
         iterm = floor_div16(gain_i * integ_sum);
         rate = derivative_rate(last_meas - longint'(r.measured_rate), dt);
         alpha = weight > 65536 ? 65536 : weight;
         deriv_filt = floor_div16(deriv_filt * (65536 - alpha) + rate * alpha);
         last_meas = r.measured_rate;
         total = pterm + iterm + deriv_filt;
      end
      return 32'(limit(total, DRIVE_MIN, DRIVE_MAX));
   endfunction

   task automatic write_register(logic [rpfd_pkg::CSR_IDX_W-1:0] idx, longint value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= rpfd_pkg::GAIN_W'(value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         rpfd_pkg::CSR_GAIN_P: gain_p = value & 64'h7FFFFFFF;
         rpfd_pkg::CSR_GAIN_I: gain_i = value & 64'h7FFFFFFF;
         rpfd_pkg::CSR_GAIN_D: gain_d = value & 64'h7FFFFFFF;
         default: weight = value & 64'h1FFFF;
      endcase
   endtask

   function automatic logic signed [31:0] rand_rate();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $signed(32'($urandom_range(0, 2000000))) - 1000000;
         2: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
         default: return $signed(32'($urandom_range(0, 40000000))) - 20000000;
      endcase
   endfunction

   function automatic request_type rand_request();
      request_type r;
      r.setpoint = rand_rate();
      r.measured_rate = rand_rate();
      case ($urandom_range(0, 9))
         0: r.step_time_us = 16'd0;
         1: r.step_time_us = 16'($urandom_range(1, 3));
         2: r.step_time_us = 16'hFFFF;
         3, 4: r.step_time_us = 16'($urandom);
         default: r.step_time_us = 16'($urandom_range(1000, 20000));
      endcase
      r.hold = ($urandom_range(0, 4) == 0);
      return r;
   endfunction

   task automatic add_request(logic signed [31:0] t, logic signed [31:0] m,
                              logic [15:0] dt, logic h);
      request_type r;
      r.setpoint = t;
      r.measured_rate = m;
      r.step_time_us = dt;
      r.hold = h;
      pending_requests.push_back(r);
   endtask

   task automatic drain();
      while (pending_requests.size() != 0 || expected_drive.size() != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_drive.push_back(controller_drive(pending_requests.pop_front()));
            requests_sent++;
            send_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
         end
         if (!(req_valid && req_stall)) begin
            if (send_wait > 0 || pending_requests.size() == 0) begin
               req_valid <= 1'b0;
               if (send_wait > 0) send_wait--;
            end else begin
               req_valid <= 1'b1;
               req_setpoint <= pending_requests[0].setpoint;
               req_measured_rate <= pending_requests[0].measured_rate;
               req_step_time_us <= pending_requests[0].step_time_us;
               req_hold <= pending_requests[0].hold;
               if (pending_requests[0].hold) hold_count++;
               if (pending_requests[0].step_time_us == 0) zero_dt_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            responses++;
            recv_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
            if (expected_drive.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response drive=%0d", rsp_drive);
            end else if (rsp_drive !== expected_drive[0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("drive mismatch: expected %0d actual %0d",
                           expected_drive[0], rsp_drive);
               void'(expected_drive.pop_front());
            end else begin
               void'(expected_drive.pop_front());
            end
         end
         if (recv_wait > 0) begin
            rsp_stall <= 1'b1;
            recv_wait--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      gain_p = rpfd_pkg::GAIN_P_RESET;
      gain_i = rpfd_pkg::GAIN_I_RESET;
      gain_d = rpfd_pkg::GAIN_D_RESET;
      weight = rpfd_pkg::WEIGHT_RESET;
      integ_sum = 0;
      last_meas = 0;
      deriv_filt = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      add_request(32'sd65536, 32'sd0, 16'd1000, 1'b0);
      add_request(32'h7FFFFFFF, 32'h80000000, 16'hFFFF, 1'b0);
      add_request(32'h80000000, 32'h7FFFFFFF, 16'hFFFF, 1'b0);
      add_request(32'sd100, 32'sd5, 16'd0, 1'b0);
      add_request(32'sd100, 32'sd5, 16'd0, 1'b1);
      add_request(32'h7FFFFFFF, 32'h80000000, 16'd1, 1'b1);
      add_request(32'h80000000, 32'h7FFFFFFF, 16'd1, 1'b0);
      add_request(32'sd0, 32'h7FFFFFFF, 16'd1, 1'b0);
      add_request(32'sd0, 32'h80000000, 16'd1, 1'b0);
      add_request(32'sd0, 32'sd0, 16'd2, 1'b1);
      add_request(-32'sd1, 32'sd0, 16'd1, 1'b0);
      add_request(32'sd1, -32'sd1, 16'd3, 1'b0);
      drain();

      write_register(rpfd_pkg::CSR_GAIN_P, 64'h7FFFFFFF);
      write_register(rpfd_pkg::CSR_GAIN_I, 64'h7FFFFFFF);
      write_register(rpfd_pkg::CSR_GAIN_D, 64'h7FFFFFFF);
      write_register(rpfd_pkg::CSR_WEIGHT, 64'd65536);
      add_request(32'h7FFFFFFF, 32'h80000000, 16'hFFFF, 1'b0);
      add_request(32'h80000000, 32'h7FFFFFFF, 16'd1, 1'b0);
      add_request(32'sd5, 32'sd3, 16'd1, 1'b1);
      drain();
      write_register(rpfd_pkg::CSR_GAIN_P, 0);
      write_register(rpfd_pkg::CSR_GAIN_I, 0);
      write_register(rpfd_pkg::CSR_GAIN_D, 0);
      write_register(rpfd_pkg::CSR_WEIGHT, 0);
      add_request(32'h7FFFFFFF, 32'h80000000, 16'd5, 1'b0);
      add_request(32'sd7, 32'sd9, 16'd5, 1'b1);
      drain();
      write_register(rpfd_pkg::CSR_WEIGHT, 64'h1FFFF);
      write_register(rpfd_pkg::CSR_GAIN_D, 64'd70000);
      add_request(32'sd0, 32'sd655360, 16'd2, 1'b0);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               write_register(rpfd_pkg::CSR_GAIN_P, rpfd_pkg::GAIN_P_RESET);
               write_register(rpfd_pkg::CSR_GAIN_I, rpfd_pkg::GAIN_I_RESET);
               write_register(rpfd_pkg::CSR_GAIN_D, rpfd_pkg::GAIN_D_RESET);
               write_register(rpfd_pkg::CSR_WEIGHT, rpfd_pkg::WEIGHT_RESET);
            end
            1, 2, 3: begin
               write_register(rpfd_pkg::CSR_GAIN_P,
                              $urandom_range(0, 1) ? $urandom : $urandom_range(0, 200000));
               write_register(rpfd_pkg::CSR_GAIN_I,
                              $urandom_range(0, 1) ? $urandom : $urandom_range(0, 200000));
               write_register(rpfd_pkg::CSR_GAIN_D,
                              $urandom_range(0, 1) ? $urandom : $urandom_range(0, 20000));
               write_register(rpfd_pkg::CSR_WEIGHT, $urandom_range(0, 131071));
            end
            4: begin
               write_register(rpfd_pkg::CSR_GAIN_P, 64'h7FFFFFFF);
               write_register(rpfd_pkg::CSR_GAIN_I, 64'h7FFFFFFF);
               write_register(rpfd_pkg::CSR_GAIN_D, 64'h7FFFFFFF);
               write_register(rpfd_pkg::CSR_WEIGHT, 64'd65536);
            end
            default: begin
               write_register(rpfd_pkg::CSR_GAIN_P, 64'd1);
               write_register(rpfd_pkg::CSR_GAIN_I, 64'd1);
               write_register(rpfd_pkg::CSR_GAIN_D, 64'd1);
               write_register(rpfd_pkg::CSR_WEIGHT, 64'd1);
            end
         endcase
         for (int k = 0; k < 200; k++)
            pending_requests.push_back(rand_request());
         drain();
      end

      $display("%0d requests, %0d responses; %0d in hold mode, %0d with zero step time",
               requests_sent, responses, hold_count, zero_dt_count);
      $display("gain and weight settings swept from zero to full scale; mismatches: %0d",
               mismatches);
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
